// File: sv/cwfb_pkg.sv
// Shared types, frame constants and the CRC-16/MODBUS byte update for the
// write-single-coil frame builder. No dependencies.
package cwfb_pkg;

    // One request word: which coil and whether to switch it on.
    typedef struct packed {
        logic [7:0] channel;
        logic       switch_on;
    } t_req;

    // One result word: a frame byte and the end-of-frame flag.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_rsp;

    typedef logic [2:0] t_idx;

    localparam logic [7:0]  DEV_ADDR_RESET  = 8'h01;
    localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
    localparam logic [7:0]  COIL_ADDR_HI    = 8'h00;
    localparam logic [7:0]  VALUE_ON        = 8'hFF;
    localparam logic [7:0]  VALUE_OFF       = 8'h00;
    localparam logic [7:0]  VALUE_LO        = 8'h00;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    // Position of each byte in the frame, in wire order.
    localparam t_idx IDX_ADDR     = 3'd0;
    localparam t_idx IDX_FUNC     = 3'd1;
    localparam t_idx IDX_COIL_HI  = 3'd2;
    localparam t_idx IDX_COIL_LO  = 3'd3;
    localparam t_idx IDX_VALUE_HI = 3'd4;
    localparam t_idx IDX_VALUE_LO = 3'd5;
    localparam t_idx IDX_CRC_LO   = 3'd6;
    localparam t_idx IDX_CRC_HI   = 3'd7;

    // Folds one byte into the running CRC, eight bit steps, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/cwfb_in_reg.sv
// Input holding register for coil requests.
// Depends on cwfb_pkg for the request word type.
module cwfb_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cwfb_pkg::t_req i_in_data,
    input  logic          i_take,
    output logic          o_req_valid,
    output cwfb_pkg::t_req o_req
);

    logic           r_valid;
    cwfb_pkg::t_req r_req;
    logic           n_valid;
    logic           accept;

    // The held word may be replaced in the same cycle the serializer takes it.
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_req <= i_in_data;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

// File: sv/cwfb_serializer.sv
// Frame serializer: emits the eight frame bytes from an output register and
// folds the body bytes into the CRC as they go out. Depends on cwfb_pkg.
module cwfb_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  cwfb_pkg::t_req i_req,
    input  logic [7:0]     i_dev_addr,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cwfb_pkg::t_rsp o_out_data
);

    logic            r_valid;
    cwfb_pkg::t_idx  r_idx;
    logic [15:0]     r_crc;
    logic [7:0]      r_channel;
    logic            r_switch_on;
    logic [7:0]      r_byte;
    logic            r_last;

    logic            advance;
    cwfb_pkg::t_idx  n_idx;
    logic [15:0]     n_crc;
    logic [7:0]      n_byte;

    assign advance = !r_valid || !i_out_stall;
    assign o_take  = advance && i_req_valid && (!r_valid || r_last);

    always_comb begin
        n_idx = r_idx + 3'd1;
        n_crc = r_crc;
        if (r_idx < cwfb_pkg::IDX_CRC_LO) begin
            n_crc = cwfb_pkg::crc_byte(r_crc, r_byte);
        end
        case (n_idx)
            cwfb_pkg::IDX_FUNC:     n_byte = cwfb_pkg::FUNC_WRITE_COIL;
            cwfb_pkg::IDX_COIL_HI:  n_byte = cwfb_pkg::COIL_ADDR_HI;
            cwfb_pkg::IDX_COIL_LO:  n_byte = r_channel;
            cwfb_pkg::IDX_VALUE_HI: n_byte = r_switch_on ? cwfb_pkg::VALUE_ON
                                                         : cwfb_pkg::VALUE_OFF;
            cwfb_pkg::IDX_VALUE_LO: n_byte = cwfb_pkg::VALUE_LO;
            cwfb_pkg::IDX_CRC_LO:   n_byte = n_crc[7:0];
            cwfb_pkg::IDX_CRC_HI:   n_byte = r_crc[15:8];
            default:                n_byte = i_dev_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= cwfb_pkg::IDX_ADDR;
            r_last  <= 1'b0;
        end else if (o_take) begin
            r_valid     <= 1'b1;
            r_idx       <= cwfb_pkg::IDX_ADDR;
            r_last      <= 1'b0;
            r_crc       <= cwfb_pkg::CRC_INIT;
            r_channel   <= i_req.channel;
            r_switch_on <= i_req.switch_on;
            r_byte      <= i_dev_addr;
        end else if (advance && r_valid) begin
            if (r_last) begin
                r_valid <= 1'b0;
                r_last  <= 1'b0;
            end else begin
                r_idx  <= n_idx;
                r_crc  <= n_crc;
                r_byte <= n_byte;
                r_last <= (n_idx == cwfb_pkg::IDX_CRC_HI);
            end
        end
    end

    assign o_out_valid           = r_valid;
    assign o_out_data.frame_byte = r_byte;
    assign o_out_data.last_byte  = r_last;

endmodule

// File: sv/coil_write_frame_builder.sv
// Top level of the Modbus RTU write-single-coil frame builder.
// Depends on cwfb_pkg, cwfb_in_reg and cwfb_serializer.
//
//   channel   direction  handshake          word
//   in        input      valid / stall      t_req: channel, switch_on
//   out       output     valid / stall      t_rsp: frame_byte, last_byte
//   cfg       input      valid / ready      device address, 8 bits
//
// Each request produces eight output words, one per cycle when the output
// is not stalled, from the serializer's single byte-wide output register.
// A request is held in an input register while the previous frame drains,
// so the next frame's first word follows the previous frame's last word
// with no gap. Reset is synchronous and active low; it empties both
// registers and sets the device address to 1. An output stall freezes the
// output word; an input stall is raised only while a request waits in the
// input register and the current frame goes on.
module coil_write_frame_builder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cwfb_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cwfb_pkg::t_rsp o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);

    // The slave address register. Writes must arrive only while the block is idle;
    // the block does not enforce this. The serializer samples it at the start of each frame.
    logic [7:0]     r_dev_addr;

    logic           req_valid;
    cwfb_pkg::t_req req;
    logic           take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= cwfb_pkg::DEV_ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    // Request holding register: parts the input side from the frame output.
    cwfb_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_take      (take),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    // Serializer: builds the frame a byte at a time and computes the CRC
    // over the six body bytes as they leave, low CRC byte first.
    cwfb_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .i_dev_addr  (r_dev_addr),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sv/cwfb_checker.sv
// Port-level checks for the frame builder, bound to the top level.
// Depends on cwfb_pkg and coil_write_frame_builder.
module cwfb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input cwfb_pkg::t_rsp o_out_data
);

    cwfb_pkg::t_idx r_pos;
    logic           out_acc;

    assign out_acc = o_out_valid && !i_out_stall;

    // Position of the next delivered word within its frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= cwfb_pkg::IDX_ADDR;
        end else if (out_acc) begin
            r_pos <= r_pos + 3'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_out_data.last_byte == (r_pos == cwfb_pkg::IDX_CRC_HI)))
        else $error("frame end flag out of place");

    a_func_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_pos == cwfb_pkg::IDX_FUNC) |->
            (o_out_data.frame_byte == cwfb_pkg::FUNC_WRITE_COIL))
        else $error("wrong function code");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output is empty");

endmodule

bind coil_write_frame_builder cwfb_checker u_cwfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
